>>> hdl/crcpd_pkg.sv
// Shared types and constants of the CRC-16 packet deframer.
package crcpd_pkg;

  // Frame format
  localparam int unsigned MAX_PAYLOAD = 16;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned LEN_W       = 5;
  localparam logic [7:0]  SYNC_BYTE   = 8'hA5;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  // Idle timer
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam int unsigned IDLE_W        = 17;
  localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

  // Input kinds and result status codes
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_TICK   = 1'b1;
  localparam logic STAT_PACKET = 1'b0;
  localparam logic STAT_TMO    = 1'b1;

  typedef enum logic [2:0] {
    PS_SYNC1,
    PS_SYNC2,
    PS_ID,
    PS_CMD,
    PS_LEN,
    PS_DATA,
    PS_CRC_HI,
    PS_CRC_LO
  } parse_state_t;

  // One result item
  typedef struct packed {
    logic             status;
    logic [7:0]       packet_id;
    logic [7:0]       command;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       data_value;
    logic [IDX_W-1:0] byte_index;
    logic             last;
  } result_t;

  // Header fields of the frame being parsed or emitted
  typedef struct packed {
    logic [7:0]       id;
    logic [7:0]       cmd;
    logic [LEN_W-1:0] len;
  } header_t;

  // Per-item events from the parser to the emitter
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             run_start;
    logic             res_v;
    result_t          res;
  } parse_evt_t;

endpackage

>>> hdl/crcpd_if.sv
// Valid/ready channel interfaces for the deframer input and result streams.
interface crcpd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface crcpd_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] packet_id;
  logic [7:0] command;
  logic [4:0] payload_length;
  logic [7:0] data_value;
  logic [3:0] byte_index;
  logic       last;

  modport source (output valid, output status, output packet_id, output command,
                  output payload_length, output data_value, output byte_index,
                  output last, input ready);
  modport sink   (input valid, input status, input packet_id, input command,
                  input payload_length, input data_value, input byte_index,
                  input last, output ready);
endinterface

>>> hdl/crcpd_parser.sv
// Frame parser: sync hunt, header capture, CRC-16 update and idle timeout.
module crcpd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic                 kind,
  input  logic [7:0]           rx_byte,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  output crcpd_pkg::parse_evt_t evt,
  output crcpd_pkg::header_t   hdr
);

  crcpd_pkg::parse_state_t state_r, state_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [crcpd_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [crcpd_pkg::LEN_W-1:0] fill_r, fill_nxt;
  logic [crcpd_pkg::IDLE_W-1:0] idle_r, idle_nxt;
  logic [15:0] timeout_r;

  logic [crcpd_pkg::IDLE_W-1:0] idle_inc;
  logic [crcpd_pkg::LEN_W-1:0]  fill_inc;
  logic [15:0] crc_upd;
  logic        is_sync;
  logic        tmo_hit;

  // Byte-wise CRC-16/CCITT-FALSE step
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] dat);
    logic [7:0] x;
    logic [7:0] hi;
    logic [7:0] lo;
    x  = crc[15:8] ^ dat;
    x  = x ^ (x >> 4);
    hi = crc[7:0] ^ (x << 4) ^ (x >> 3);
    lo = (x << 5) ^ x;
    return {hi, lo};
  endfunction

  assign is_sync  = (rx_byte == crcpd_pkg::SYNC_BYTE);
  assign crc_upd  = crc_byte(crc_r, rx_byte);
  assign fill_inc = fill_r + 1'b1;
  assign idle_inc = (idle_r == crcpd_pkg::IDLE_MAX) ? idle_r : idle_r + 1'b1;
  assign tmo_hit  = (idle_inc > {1'b0, timeout_r});

  assign hdr.id  = id_r;
  assign hdr.cmd = cmd_r;
  assign hdr.len = len_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (fire) begin
      if (kind == crcpd_pkg::KIND_TICK) begin
        if (tmo_hit) state_nxt = crcpd_pkg::PS_SYNC1;
      end else begin
        unique case (state_r)
          crcpd_pkg::PS_SYNC1: state_nxt = is_sync ? crcpd_pkg::PS_SYNC2 : crcpd_pkg::PS_SYNC1;
          crcpd_pkg::PS_SYNC2: state_nxt = is_sync ? crcpd_pkg::PS_ID : crcpd_pkg::PS_SYNC1;
          crcpd_pkg::PS_ID:    state_nxt = crcpd_pkg::PS_CMD;
          crcpd_pkg::PS_CMD:   state_nxt = crcpd_pkg::PS_LEN;
          crcpd_pkg::PS_LEN: begin
            if (rx_byte == 8'd0)
              state_nxt = crcpd_pkg::PS_CRC_HI;
            else if (rx_byte > 8'(crcpd_pkg::MAX_PAYLOAD))
              state_nxt = crcpd_pkg::PS_SYNC1;
            else
              state_nxt = crcpd_pkg::PS_DATA;
          end
          crcpd_pkg::PS_DATA:
            state_nxt = (fill_inc >= len_r) ? crcpd_pkg::PS_CRC_HI : crcpd_pkg::PS_DATA;
          crcpd_pkg::PS_CRC_HI:
            state_nxt = (rx_byte == crc_r[15:8]) ? crcpd_pkg::PS_CRC_LO : crcpd_pkg::PS_SYNC1;
          crcpd_pkg::PS_CRC_LO: state_nxt = crcpd_pkg::PS_SYNC1;
        endcase
      end
    end
  end

  // Datapath updates and events
  always_comb begin
    crc_nxt  = crc_r;
    id_nxt   = id_r;
    cmd_nxt  = cmd_r;
    len_nxt  = len_r;
    fill_nxt = fill_r;
    idle_nxt = idle_r;
    evt      = '0;
    evt.wr_data = rx_byte;
    evt.wr_addr = fill_r[crcpd_pkg::IDX_W-1:0];
    if (fire) begin
      if (kind == crcpd_pkg::KIND_TICK) begin
        if (tmo_hit) begin
          idle_nxt       = '0;
          evt.res_v      = 1'b1;
          evt.res.status = crcpd_pkg::STAT_TMO;
          evt.res.last   = 1'b1;
        end else begin
          idle_nxt = idle_inc;
        end
      end else begin
        idle_nxt = '0;
        unique case (state_r)
          crcpd_pkg::PS_SYNC1: begin
            if (is_sync) crc_nxt = crc_byte(crcpd_pkg::CRC_INIT, crcpd_pkg::SYNC_BYTE);
          end
          crcpd_pkg::PS_SYNC2: begin
            if (is_sync) crc_nxt = crc_upd;
          end
          crcpd_pkg::PS_ID: begin
            id_nxt  = rx_byte;
            crc_nxt = crc_upd;
          end
          crcpd_pkg::PS_CMD: begin
            cmd_nxt = rx_byte;
            crc_nxt = crc_upd;
          end
          crcpd_pkg::PS_LEN: begin
            len_nxt  = rx_byte[crcpd_pkg::LEN_W-1:0];
            fill_nxt = '0;
            crc_nxt  = crc_upd;
          end
          crcpd_pkg::PS_DATA: begin
            evt.wr_en = (fill_r < crcpd_pkg::LEN_W'(crcpd_pkg::MAX_PAYLOAD));
            fill_nxt  = fill_inc;
            crc_nxt   = crc_upd;
          end
          crcpd_pkg::PS_CRC_HI: ;
          crcpd_pkg::PS_CRC_LO: begin
            if (rx_byte == crc_r[7:0]) begin
              if (len_r == '0) begin
                // empty payload: one result with zero data
                evt.res_v              = 1'b1;
                evt.res.status         = crcpd_pkg::STAT_PACKET;
                evt.res.packet_id      = id_r;
                evt.res.command        = cmd_r;
                evt.res.payload_length = len_r;
                evt.res.last           = 1'b1;
              end else begin
                evt.run_start = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= crcpd_pkg::PS_SYNC1;
      crc_r     <= crcpd_pkg::CRC_INIT;
      id_r      <= '0;
      cmd_r     <= '0;
      len_r     <= '0;
      fill_r    <= '0;
      idle_r    <= '0;
      timeout_r <= crcpd_pkg::TIMEOUT_RESET;
    end else begin
      state_r <= state_nxt;
      crc_r   <= crc_nxt;
      id_r    <= id_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      fill_r  <= fill_nxt;
      idle_r  <= idle_nxt;
      if (cfg_we) timeout_r <= cfg_wdata;
    end
  end

endmodule

>>> hdl/crcpd_emitter.sv
// Payload memory, result run sequencer and two-deep output buffer.
module crcpd_emitter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  crcpd_pkg::parse_evt_t evt,
  input  crcpd_pkg::header_t    hdr,
  input  logic                  out_ready,
  output logic                  out_valid,
  output crcpd_pkg::result_t    out_res,
  output logic                  room
);

  logic [7:0] mem [crcpd_pkg::MAX_PAYLOAD];
  logic [7:0] rd_data_r;

  logic                       emit_active_r, emit_active_nxt;
  logic [crcpd_pkg::IDX_W-1:0] emit_idx_r, emit_idx_nxt;
  logic                       out_v_r, out_v_nxt;
  crcpd_pkg::result_t         out_r, out_nxt;
  logic                       skid_v_r, skid_v_nxt;
  crcpd_pkg::result_t         skid_r, skid_nxt;

  logic               out_free;
  logic               load_run;
  logic               run_last;
  crcpd_pkg::result_t run_res;

  assign out_free = !out_v_r || out_ready;
  assign load_run = emit_active_r && out_free && !skid_v_r;
  assign run_last = ({1'b0, emit_idx_r} + 1'b1) == hdr.len;
  assign room     = !emit_active_r && !skid_v_r;

  assign out_valid = out_v_r;
  assign out_res   = out_r;

  // Result for the current run position
  always_comb begin
    run_res                = '0;
    run_res.status         = crcpd_pkg::STAT_PACKET;
    run_res.packet_id      = hdr.id;
    run_res.command        = hdr.cmd;
    run_res.payload_length = hdr.len;
    run_res.data_value     = rd_data_r;
    run_res.byte_index     = emit_idx_r;
    run_res.last           = run_last;
  end

  // Run sequencer; the read address is the run position of the next cycle
  always_comb begin
    emit_active_nxt = emit_active_r;
    emit_idx_nxt    = emit_idx_r;
    if (evt.run_start) begin
      emit_active_nxt = 1'b1;
      emit_idx_nxt    = '0;
    end else if (load_run) begin
      if (run_last) emit_active_nxt = 1'b0;
      else          emit_idx_nxt    = emit_idx_r + 1'b1;
    end
  end

  // Output register and skid stage
  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (out_free) begin
      priority if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end else if (evt.res_v) begin
        out_v_nxt = 1'b1;
        out_nxt   = evt.res;
      end else if (load_run) begin
        out_v_nxt = 1'b1;
        out_nxt   = run_res;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (evt.res_v) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = evt.res;
    end
  end

  // Payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (evt.wr_en) mem[evt.wr_addr] <= evt.wr_data;
    rd_data_r <= mem[emit_idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_active_r <= 1'b0;
      emit_idx_r    <= '0;
      out_v_r       <= 1'b0;
      skid_v_r      <= 1'b0;
    end else begin
      emit_active_r <= emit_active_nxt;
      emit_idx_r    <= emit_idx_nxt;
      out_v_r       <= out_v_nxt;
      skid_v_r      <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

`ifndef NO_ASSERTIONS
  // skid stage only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid full while output empty");

  // a run position stays inside the payload
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    emit_active_r |-> ({1'b0, emit_idx_r} < hdr.len)) else $error("run index past length");

  // a run starts at position zero
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    evt.run_start |=> (emit_active_r && emit_idx_r == '0)) else $error("bad run start");

  // the final result of a run ends the run
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (load_run && run_last) |=> !emit_active_r) else $error("run did not end");
`endif

endmodule

>>> hdl/crc16_packet_deframer.sv
// Timeout and empty-payload results are registered in the output register, or in the skid
// stage if it is held; a good frame's first payload result passes the read register first.
// Throughput: one input item per cycle; input is held off while the skid stage is full
// or a run of N results drains from payload memory (one result per cycle unless out_ready stalls).
// Reset (rst_n, synchronous): parser hunts for sync, buffers empty, timeout 5000.
// The payload memory is not cleared; results carry only entries written by their own frame.
module crc16_packet_deframer (
  input  logic              clk,
  input  logic              rst_n,
  crcpd_in_if.sink          in_ch,
  crcpd_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);

  crcpd_pkg::parse_evt_t evt;
  crcpd_pkg::header_t    hdr;
  crcpd_pkg::result_t    res;
  logic                  room;
  logic                  in_fire;

  assign in_ch.ready = room;
  assign in_fire     = in_ch.valid && room;

  crcpd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .kind      (in_ch.kind),
    .rx_byte   (in_ch.rx_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .evt       (evt),
    .hdr       (hdr)
  );

  crcpd_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt       (evt),
    .hdr       (hdr),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_res   (res),
    .room      (room)
  );

  // Result fields onto the channel
  assign out_ch.status         = res.status;
  assign out_ch.packet_id      = res.packet_id;
  assign out_ch.command        = res.command;
  assign out_ch.payload_length = res.payload_length;
  assign out_ch.data_value     = res.data_value;
  assign out_ch.byte_index     = res.byte_index;
  assign out_ch.last           = res.last;

endmodule
